// File: src/ssfh_pkg.sv
`timescale 1ns / 1ps

package ssfh_pkg;

	// Frame markers on the serial link.
	localparam logic [7:0] START_BYTE = 8'h9b;
	localparam logic [7:0] END_BYTE   = 8'h9d;

	// Bit 7 of the middle digit byte carries the decimal point.
	localparam int unsigned POINT_BIT = 7;

	// Frame lengths that carry height digits.
	localparam logic [7:0] LEN_SHORT = 8'd7;
	localparam logic [7:0] LEN_LONG  = 8'd10;

	// Depth of the received byte history.
	localparam int unsigned HIST_DEPTH = 5;

	localparam int unsigned HEIGHT_W = 14;
	localparam int unsigned RAW_W    = 11;

	// Configuration register indexes.
	localparam logic REG_CHANGE_THRESHOLD = 1'b0;
	localparam logic REG_EXPECTED_TYPE    = 1'b1;

	localparam logic [7:0] THRESHOLD_RESET = 8'd1;
	localparam logic [7:0] TYPE_RESET      = 8'd18;

	typedef logic [HEIGHT_W-1:0] height_t;

	// Status handed from the frame tracker to the publisher for one word.
	typedef struct packed {
		logic    fire;
		logic    end_byte;
		height_t height;
	} ssfh_track_t;

	// Seven-segment pattern to digit; a lone dash reads as ten, and any
	// unknown pattern reads as zero. Bit 7 is not part of the pattern.
	function automatic logic [3:0] seg_decode(input logic [7:0] v);
		logic [3:0] d;
		begin
			case (v[6:0])
				7'h3f: d = 4'd0;
				7'h06: d = 4'd1;
				7'h5b: d = 4'd2;
				7'h4f: d = 4'd3;
				7'h66: d = 4'd4;
				7'h6d: d = 4'd5;
				7'h7d: d = 4'd6;
				7'h07: d = 4'd7;
				7'h7f: d = 4'd8;
				7'h6f: d = 4'd9;
				7'h40: d = 4'd10;
				default: d = 4'd0;
			endcase
			return d;
		end
	endfunction

endpackage

// File: src/ssfh_ifs.sv
`timescale 1ns / 1ps

// Channel carrying received serial bytes.
interface ssfh_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// Channel carrying published heights.
interface ssfh_height_if;
	logic        valid;
	logic        ready;
	logic [13:0] height_tenths;

	modport source (output valid, output height_tenths, input ready);
	modport sink (input valid, input height_tenths, output ready);
endinterface

// File: src/ssfh_frame_tracker.sv
`timescale 1ns / 1ps

module ssfh_frame_tracker
	import ssfh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  byte_s1,
	input  logic [7:0]  expected_type,
	output ssfh_track_t trk
);

	logic [7:0] hist_q [HIST_DEPTH];
	logic [7:0] len_q;
	logic [7:0] type_q;
	logic       valid_q;
	height_t    height_q;

	logic [7:0] len_n;
	logic [7:0] type_n;
	logic       valid_n;
	height_t    height_n;
	logic [3:0] d_hund;
	logic [3:0] d_tens;
	logic [3:0] d_ones;
	logic [RAW_W-1:0] raw;
	height_t    raw_ext;

	// Frame header tracking, checked against the history before the shift.
	always_comb begin
		len_n   = len_q;
		type_n  = type_q;
		valid_n = valid_q;
		if (byte_s1 == START_BYTE) begin
			len_n   = 8'd0;
			valid_n = 1'b0;
		end
		if (hist_q[0] == START_BYTE) begin
			len_n = byte_s1;
		end
		if (hist_q[1] == START_BYTE) begin
			type_n = byte_s1;
		end
		if (hist_q[2] == START_BYTE) begin
			if ((type_n == expected_type) && (len_n inside {LEN_SHORT, LEN_LONG}) &&
			    (byte_s1 != 8'd0) && (seg_decode(byte_s1) != 4'd0)) begin
				valid_n = 1'b1;
			end
		end
	end

	// Three digits to a height in tenths; without a point the value is whole units.
	always_comb begin
		d_hund  = seg_decode(hist_q[1]);
		d_tens  = seg_decode(hist_q[0]);
		d_ones  = seg_decode(byte_s1);
		raw     = ({7'd0, d_hund} * RAW_W'(100)) + ({7'd0, d_tens} * RAW_W'(10)) +
		          {7'd0, d_ones};
		raw_ext = {{(HEIGHT_W-RAW_W){1'b0}}, raw};
		height_n = height_q;
		if ((hist_q[4] == START_BYTE) && valid_n) begin
			if (hist_q[0][POINT_BIT]) begin
				height_n = raw_ext;
			end else begin
				height_n = (raw_ext << 3) + (raw_ext << 1);
			end
		end
	end

	// State advances once per processed word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_q[i] <= 8'd0;
			end
			len_q    <= 8'd0;
			type_q   <= 8'd0;
			valid_q  <= 1'b0;
			height_q <= '0;
		end else if (fire) begin
			for (int i = HIST_DEPTH - 1; i > 0; i--) begin
				hist_q[i] <= hist_q[i-1];
			end
			hist_q[0] <= byte_s1;
			len_q     <= len_n;
			type_q    <= type_n;
			valid_q   <= valid_n;
			height_q  <= height_n;
		end
	end

	assign trk.fire     = fire;
	assign trk.end_byte = (byte_s1 == END_BYTE);
	assign trk.height   = height_n;

endmodule

// File: src/ssfh_publisher.sv
`timescale 1ns / 1ps

module ssfh_publisher
	import ssfh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ssfh_track_t trk,
	input  logic [7:0]  change_threshold,
	output logic        advance,
	ssfh_height_if.source result
);

	height_t last_q;
	height_t diff;
	logic    publish;
	logic    out_valid_q;
	height_t out_data_q;

	// The result register frees up when empty or when its word is taken.
	assign advance = !out_valid_q || result.ready;

	// Absolute change against the last published height.
	always_comb begin
		if (trk.height >= last_q) begin
			diff = trk.height - last_q;
		end else begin
			diff = last_q - trk.height;
		end
		publish = trk.fire && trk.end_byte &&
		          (diff > {{(HEIGHT_W-8){1'b0}}, change_threshold});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= publish;
			end
			if (publish) begin
				last_q <= trk.height;
			end
		end
	end

	// Payload register needs no reset.
	always_ff @(posedge clk) begin
		if (publish) begin
			out_data_q <= trk.height;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.height_tenths = out_data_q;

endmodule

// File: src/seven_segment_frame_height_decoder_core.sv
`timescale 1ns / 1ps

// Seven-segment frame height decoder. Received serial bytes enter on rx, one
// word per cycle when the result side is not stalled; an accepted byte passes
// through the input register and then through the frame decode into the result
// register. A frame opens with 0x9b, followed by length, type and three
// seven-segment digits; a valid frame updates the height in tenths of a unit,
// and each 0x9d byte publishes that height on result if it moved by more
// than change_threshold since the last publish. Registers: index 0 is
// change_threshold (reset 1), index 1 is expected_type (reset 18); write them
// only while the block is idle.
module seven_segment_frame_height_decoder_core
	import ssfh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	ssfh_rx_if.sink        rx,
	ssfh_height_if.source  result
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        fire;
	logic [7:0]  threshold_q;
	logic [7:0]  exp_type_q;
	ssfh_track_t trk;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			exp_type_q  <= TYPE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHANGE_THRESHOLD: threshold_q <= cfg_data;
				REG_EXPECTED_TYPE:    exp_type_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: refills when empty or whenever its word moves on.
	assign rx.ready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	ssfh_frame_tracker u_tracker (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.byte_s1       (byte_s1),
		.expected_type (exp_type_q),
		.trk           (trk)
	);

	ssfh_publisher u_publisher (
		.clk              (clk),
		.arst_n           (arst_n),
		.trk              (trk),
		.change_threshold (threshold_q),
		.advance          (advance),
		.result           (result)
	);

endmodule

// File: src/ssfh_checker.sv
`timescale 1ns / 1ps

module ssfh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_valid,
	input logic        rx_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [13:0] res_height
);

	// A stalled result word holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_height)))
		else $error("result word changed while stalled");

	// A fresh result traces back to a byte accepted on rx.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(rx_valid && rx_ready, 2))
		else $error("result appeared without an accepted byte");

	// Input side never waits while the result side is free.
	a_no_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid && !res_ready) |-> rx_ready)
		else $error("input stalled with a free result register");

	// Decoded heights never exceed three dashes in whole units.
	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_height <= 14'd11100))
		else $error("published height out of range");

endmodule

bind seven_segment_frame_height_decoder_core ssfh_checker u_ssfh_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rx_valid   (rx.valid),
	.rx_ready   (rx.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_height (result.height_tenths)
);
